@@ src/cau_pkg.sv @@
// Shared types, codes and helpers of the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 64;
  localparam int MAG_W  = 48;
  // Quotient bits resolved by the divider chain, one per cell.
  localparam int QUOT_BITS = 33;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_NEG  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // What the back end still has to do with a transaction.
  localparam logic [1:0] K_DONE = 2'd0;
  localparam logic [1:0] K_MUL  = 2'd1;
  localparam logic [1:0] K_DIV  = 2'd2;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] z_re;
    logic signed [DATA_W-1:0] z_im;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic                 neg;
    logic                 big;
    logic [PROD_W-1:0]    rem;
    logic [QUOT_BITS-1:0] low;
    logic [QUOT_BITS-1:0] q;
  } lane_t;

  typedef struct packed {
    logic [1:0]        kind;
    rsp_t              rsp;
    logic [PROD_W-1:0] d;
    lane_t             re;
    lane_t             im;
  } work_t;

  // Clamp sign and magnitude to Q16.16; top bit of the result is the saturation flag.
  function automatic logic [DATA_W:0] clamp_q(input logic neg, input logic [MAG_W-1:0] mag);
    logic [DATA_W:0] r;
    if (!neg) begin
      if (mag > 48'h0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[DATA_W-1:0]};
    end else begin
      if (mag > 48'h0000_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'd0 - mag[DATA_W-1:0]};
    end
    return r;
  endfunction

endpackage

@@ src/cau_stream_if.sv @@
// Valid/ready stream channel carrying one payload per transaction.
`timescale 1ns / 1ps
interface cau_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/cau_front.sv @@
// Front end: operand products, sign-magnitude sums, simple ops and divider setup.
`timescale 1ns / 1ps
module cau_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cau_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cau_pkg::work_t out_data
);
  import cau_pkg::*;

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? 32'd0 - x : x;
  endfunction

  function automatic logic [DATA_W:0] mag33(input logic [DATA_W:0] x);
    return x[DATA_W] ? 33'd0 - x : x;
  endfunction

  function automatic logic [PROD_W:0] sm_add(input logic n1, input logic [PROD_W-1:0] m1,
                                              input logic n2, input logic [PROD_W-1:0] m2);
    logic [PROD_W-1:0] m;
    logic n;
    if (n1 == n2) begin
      m = m1 + m2;
      n = n1;
    end else if (m1 >= m2) begin
      m = m1 - m2;
      n = n1;
    end else begin
      m = m2 - m1;
      n = n2;
    end
    if (m == '0) n = 1'b0;
    return {n, m};
  endfunction

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // stage 1: products
  req_t              r1;
  logic              div0_1;
  logic [PROD_W-1:0] p_rr, p_ii, p_ir, p_ri, p_br, p_bi;
  logic              s_rr, s_ii, s_ir, s_ri;

  // stage 2: sums
  logic [1:0]        kind2;
  rsp_t              rsp2;
  logic [PROD_W-1:0] d2, m_re2, m_im2;
  logic              n_re2, n_im2;

  work_t w3;

  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;
  assign out_data = w3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      r1     <= in_data;
      div0_1 <= (in_data.b_re == '0) && (in_data.b_im == '0);
      p_rr   <= PROD_W'(mag32(in_data.a_re)) * PROD_W'(mag32(in_data.b_re));
      p_ii   <= PROD_W'(mag32(in_data.a_im)) * PROD_W'(mag32(in_data.b_im));
      p_ir   <= PROD_W'(mag32(in_data.a_im)) * PROD_W'(mag32(in_data.b_re));
      p_ri   <= PROD_W'(mag32(in_data.a_re)) * PROD_W'(mag32(in_data.b_im));
      p_br   <= PROD_W'(mag32(in_data.b_re)) * PROD_W'(mag32(in_data.b_re));
      p_bi   <= PROD_W'(mag32(in_data.b_im)) * PROD_W'(mag32(in_data.b_im));
      s_rr   <= in_data.a_re[DATA_W-1] ^ in_data.b_re[DATA_W-1];
      s_ii   <= in_data.a_im[DATA_W-1] ^ in_data.b_im[DATA_W-1];
      s_ir   <= in_data.a_im[DATA_W-1] ^ in_data.b_re[DATA_W-1];
      s_ri   <= in_data.a_re[DATA_W-1] ^ in_data.b_im[DATA_W-1];
    end
  end

  // stage 2 logic
  logic [DATA_W:0] ar_x, ai_x, br_x, bi_x, vr, vi;
  logic [DATA_W:0] cr, ci;
  logic            n_rr, n_ii, n_ir, n_ri, is_mul;
  logic [PROD_W:0] sum_re, sum_im;
  logic [1:0]      kind_next;
  rsp_t            rsp_next;

  always_comb begin
    ar_x = {r1.a_re[DATA_W-1], r1.a_re};
    ai_x = {r1.a_im[DATA_W-1], r1.a_im};
    br_x = {r1.b_re[DATA_W-1], r1.b_re};
    bi_x = {r1.b_im[DATA_W-1], r1.b_im};
    unique case (r1.op)
      OP_ADD: begin
        vr = ar_x + br_x;
        vi = ai_x + bi_x;
      end
      OP_SUB: begin
        vr = ar_x - br_x;
        vi = ai_x - bi_x;
      end
      OP_CONJ: begin
        vr = ar_x;
        vi = 33'd0 - ai_x;
      end
      OP_NEG: begin
        vr = 33'd0 - ar_x;
        vi = 33'd0 - ai_x;
      end
      default: begin
        vr = '0;
        vi = '0;
      end
    endcase
    cr = clamp_q(vr[DATA_W], MAG_W'(mag33(vr)));
    ci = clamp_q(vi[DATA_W], MAG_W'(mag33(vi)));

    n_rr = s_rr && (p_rr != '0);
    n_ii = s_ii && (p_ii != '0);
    n_ir = s_ir && (p_ir != '0);
    n_ri = s_ri && (p_ri != '0);
    is_mul = (r1.op == OP_MUL);
    // multiply: re = rr - ii, im = ir + ri; divide: re = rr + ii, im = ir - ri
    sum_re = sm_add(n_rr, p_rr, is_mul ? (!n_ii && (p_ii != '0)) : n_ii, p_ii);
    sum_im = sm_add(n_ir, p_ir, is_mul ? n_ri : (!n_ri && (p_ri != '0)), p_ri);

    rsp_next.z_re   = cr[DATA_W-1:0];
    rsp_next.z_im   = ci[DATA_W-1:0];
    rsp_next.status = (cr[DATA_W] || ci[DATA_W]) ? ST_SAT : ST_OK;
    kind_next = K_DONE;
    if (is_mul) begin
      kind_next = K_MUL;
    end else if (r1.op == OP_DIV) begin
      if (div0_1) begin
        rsp_next.z_re   = '0;
        rsp_next.z_im   = '0;
        rsp_next.status = ST_DIV0;
      end else begin
        kind_next = K_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      kind2 <= kind_next;
      rsp2  <= rsp_next;
      d2    <= p_br + p_bi;
      n_re2 <= sum_re[PROD_W];
      m_re2 <= sum_re[PROD_W-1:0];
      n_im2 <= sum_im[PROD_W];
      m_im2 <= sum_im[PROD_W-1:0];
    end
  end

  // stage 3: divider setup, overflow when the quotient would need more bits than the chain
  function automatic lane_t setup(input logic div, input logic neg, input logic [PROD_W-1:0] m,
                                  input logic [PROD_W-1:0] d);
    lane_t l;
    logic [PROD_W-1:0] hi;
    hi    = {17'd0, m[PROD_W-1:17]};
    l.neg = neg;
    l.q   = '0;
    if (div) begin
      l.big = (hi >= d);
      l.rem = l.big ? '0 : hi;
      l.low = {m[16:0], 16'd0};
    end else begin
      l.big = 1'b0;
      l.rem = m;
      l.low = '0;
    end
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      w3.kind <= kind2;
      w3.rsp  <= rsp2;
      w3.d    <= d2;
      w3.re   <= setup(kind2 == K_DIV, n_re2, m_re2, d2);
      w3.im   <= setup(kind2 == K_DIV, n_im2, m_im2, d2);
    end
  end

endmodule

@@ src/cau_div_cell.sv @@
// Divider cell: on a divide, resolves one quotient bit of both parts; passes everything else on.
`timescale 1ns / 1ps
module cau_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cau_pkg::work_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cau_pkg::work_t out_data
);
  import cau_pkg::*;

  function automatic lane_t step(input lane_t l, input logic [PROD_W-1:0] d);
    lane_t r;
    logic [PROD_W-1:0] t;
    logic ge;
    t     = {l.rem[PROD_W-2:0], l.low[QUOT_BITS-1]};
    ge    = (t >= d);
    r     = l;
    r.rem = ge ? t - d : t;
    r.low = {l.low[QUOT_BITS-2:0], 1'b0};
    r.q   = {l.q[QUOT_BITS-2:0], ge};
    return r;
  endfunction

  logic  v;
  work_t w, w_next;

  assign in_ready  = !v || out_ready;
  assign out_valid = v;
  assign out_data  = w;

  always_comb begin
    w_next = in_data;
    if (in_data.kind == K_DIV) begin
      w_next.re = step(in_data.re, in_data.d);
      w_next.im = step(in_data.im, in_data.d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= 1'b0;
    else if (in_ready) v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) w <= w_next;
  end

endmodule

@@ src/cau_back.sv @@
// Back end: rounding of products and quotients, saturation and the output register.
`timescale 1ns / 1ps
module cau_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cau_pkg::work_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cau_pkg::rsp_t  out_data
);
  import cau_pkg::*;

  function automatic logic [MAG_W-1:0] round_mag(input logic [1:0] kind, input lane_t l,
                                                  input logic [PROD_W-1:0] d);
    logic [PROD_W-1:0] s;
    logic rnd;
    s   = l.rem + 64'h8000;
    rnd = (l.rem >= d - l.rem);
    if (kind == K_MUL) return s[PROD_W-1:16];
    else if (l.big) return '1;
    else return MAG_W'(l.q) + MAG_W'(rnd);
  endfunction

  logic             v1, v2;
  logic             rdy1, rdy2;
  logic [1:0]       kind1;
  rsp_t             rsp1, o;
  logic             neg_re, neg_im;
  logic [MAG_W-1:0] mag_re, mag_im;
  logic [DATA_W:0]  cr, ci;

  assign rdy2 = !v2 || out_ready;
  assign rdy1 = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2;
  assign out_data  = o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      kind1  <= in_data.kind;
      rsp1   <= in_data.rsp;
      neg_re <= in_data.re.neg;
      neg_im <= in_data.im.neg;
      mag_re <= round_mag(in_data.kind, in_data.re, in_data.d);
      mag_im <= round_mag(in_data.kind, in_data.im, in_data.d);
    end
  end

  assign cr = clamp_q(neg_re, mag_re);
  assign ci = clamp_q(neg_im, mag_im);

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      if (kind1 == K_DONE) begin
        o <= rsp1;
      end else begin
        o.z_re   <= cr[DATA_W-1:0];
        o.z_im   <= ci[DATA_W-1:0];
        o.status <= (cr[DATA_W] || ci[DATA_W]) ? ST_SAT : ST_OK;
      end
    end
  end

endmodule

@@ src/complex_arithmetic_unit.sv @@
// Complex arithmetic unit: add, subtract, multiply, divide, conjugate and negate on Q16.16.
// Takes one request in every cycle while the result side does not stall, and returns one
// result per request, in order. Every request passes through the divider: a chain of 33
// cells, each resolving one quotient bit of both parts on a divide; three front stages
// (products, sums, divider setup) and two back stages (rounding, saturation into the output
// register) sit around it. Any stage left empty lets the chain behind it move on, so
// requests keep being taken while a result waits.
`timescale 1ns / 1ps
module complex_arithmetic_unit (
  input  logic         clk,
  input  logic         rst,
  cau_stream_if.sink   req,
  cau_stream_if.source rsp
);
  import cau_pkg::*;

  logic  c_valid [0:QUOT_BITS];
  logic  c_ready [0:QUOT_BITS];
  work_t c_data  [0:QUOT_BITS];

  cau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_data   (req.data),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .out_data  (c_data[0])
  );

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_data   (c_data[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_data  (c_data[i+1])
    );
  end

  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid[QUOT_BITS]),
    .in_ready  (c_ready[QUOT_BITS]),
    .in_data   (c_data[QUOT_BITS]),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp.data)
  );

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.data.status == ST_DIV0) |-> (rsp.data.z_re == '0) && (rsp.data.z_im == '0))
    else $error("divide-by-zero result is not zero");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.data.status == ST_SAT) |->
      (rsp.data.z_re == 32'sh7FFF_FFFF) || (rsp.data.z_re == 32'sh8000_0000) ||
      (rsp.data.z_im == 32'sh7FFF_FFFF) || (rsp.data.z_im == 32'sh8000_0000))
    else $error("saturated status without a clamped part");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.data.status != 2'd3))
    else $error("undefined status code");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("request refused while the output stage is empty");

endmodule

@@ tb/sv/complex_arithmetic_unit_test.sv @@
// Self-checking testbench of the complex arithmetic unit with a result scoreboard.
`timescale 1ns / 1ps
module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam int ITEMS      = 1500;
  localparam int CYCLE_MAX  = 400000;
  localparam int DRAIN_WAIT = 60;
  localparam int HOLD_LEN   = 400;
  localparam int HOLD_AT    = 300;
  localparam int PAUSE_AT   = 900;

  class cau_scoreboard;
    rsp_t pending[$];
    int   errors;

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function logic [31:0] clamp(logic neg, logic [127:0] mag, inout logic sat);
      if (!neg) begin
        if (mag > 128'h7FFF_FFFF) begin
          sat = 1'b1;
          return 32'h7FFF_FFFF;
        end
        return mag[31:0];
      end
      if (mag > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'd0 - mag[31:0];
    endfunction

    function logic [31:0] clamp_wide(logic signed [127:0] v, inout logic sat);
      return clamp(v < 0, (v < 0) ? -v : v, sat);
    endfunction

    // Q32.32 sum scaled back to Q16.16, nearest with ties away from zero
    function logic [31:0] scale_mul(logic signed [127:0] v, inout logic sat);
      logic [127:0] m;
      m = (v < 0) ? -v : v;
      return clamp(v < 0, (m + 128'h8000) >> 16, sat);
    endfunction

    function logic [31:0] scale_div(logic signed [127:0] n, logic [127:0] d, inout logic sat);
      logic [127:0] m;
      logic [127:0] q;
      logic [127:0] rem;
      m = (n < 0) ? -n : n;
      q = (m << 16) / d;
      rem = (m << 16) % d;
      if (q > 128'hFF_FFFF_FFFF) q = 128'hFF_FFFF_FFFF;
      else if (rem >= d - rem) q = q + 1;
      return clamp((n < 0) && (q != 0), q, sat);
    endfunction

    function rsp_t predict(req_t r);
      logic signed [127:0] ar, ai, br, bi;
      logic [127:0] den;
      logic sat;
      rsp_t z;
      ar = r.a_re;
      ai = r.a_im;
      br = r.b_re;
      bi = r.b_im;
      sat = 1'b0;
      z = '0;
      case (r.op)
        OP_ADD: begin
          z.z_re = clamp_wide(ar + br, sat);
          z.z_im = clamp_wide(ai + bi, sat);
        end
        OP_SUB: begin
          z.z_re = clamp_wide(ar - br, sat);
          z.z_im = clamp_wide(ai - bi, sat);
        end
        OP_MUL: begin
          z.z_re = scale_mul(ar * br - ai * bi, sat);
          z.z_im = scale_mul(ai * br + ar * bi, sat);
        end
        OP_DIV: begin
          if (br == 0 && bi == 0) begin
            z.status = ST_DIV0;
          end else begin
            den = br * br + bi * bi;
            z.z_re = scale_div(ar * br + ai * bi, den, sat);
            z.z_im = scale_div(ai * br - ar * bi, den, sat);
          end
        end
        OP_CONJ: begin
          z.z_re = clamp_wide(ar, sat);
          z.z_im = clamp_wide(-ai, sat);
        end
        OP_NEG: begin
          z.z_re = clamp_wide(-ar, sat);
          z.z_im = clamp_wide(-ai, sat);
        end
        default: ;
      endcase
      if (z.status == ST_OK && sat) z.status = ST_SAT;
      return z;
    endfunction

    function void note_request(req_t r);
      pending.push_back(predict(r));
    endfunction

    task check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $display("unexpected result %h at %0t", got, $realtime);
        errors++;
      end else begin
        want = pending.pop_front();
        if (got.z_re !== want.z_re) report("z_re", got.z_re, want.z_re);
        if (got.z_im !== want.z_im) report("z_im", got.z_im, want.z_im);
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   results_seen = 0;

  cau_stream_if #(.data_t(req_t)) req_if ();
  cau_stream_if #(.data_t(rsp_t)) rsp_if ();

  complex_arithmetic_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  cau_scoreboard board = new();

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4, 5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      6: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function req_t random_request();
    req_t r;
    r.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    r.a_re = pick_operand();
    r.a_im = pick_operand();
    r.b_re = pick_operand();
    r.b_im = pick_operand();
    if (r.op == OP_DIV && $urandom_range(0, 9) == 0) begin
      r.b_re = '0;
      r.b_im = '0;
    end
    return r;
  endfunction

  function req_t make_req(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
                          logic [31:0] br, logic [31:0] bi);
    req_t r;
    r.op = op;
    r.a_re = ar;
    r.a_im = ai;
    r.b_re = br;
    r.b_im = bi;
    return r;
  endfunction

  // Hold valid across back-to-back transactions; lower it only for a gap.
  task send_request(req_t r, int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
    board.note_request(r);
  endtask

  task draw_gap(output int gap);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
  endtask

  // Result side: random stalls, one long hold-off to back up the pipeline.
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (results_seen == HOLD_AT) stall = HOLD_LEN;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      board.check_result(rsp_if.data);
      results_seen++;
    end
  end

  initial begin
    req_t directed[$];
    int gap;
    int drain;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(make_req(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h8000_0000));
    directed.push_back(make_req(OP_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_8000, 32'd1));
    directed.push_back(make_req(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000));
    directed.push_back(make_req(OP_SUB, 32'h0003_0000, 32'd0, 32'h0001_0000, 32'hFFFF_FFFF));
    directed.push_back(make_req(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                                32'hFFFF_0000));
    // rounding tie in the product, both signs
    directed.push_back(make_req(OP_MUL, 32'd1, 32'd0, 32'h0000_8000, 32'd0));
    directed.push_back(make_req(OP_MUL, 32'hFFFF_FFFF, 32'd0, 32'h0000_8000, 32'd0));
    directed.push_back(make_req(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000));
    directed.push_back(make_req(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000));
    directed.push_back(make_req(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0));
    directed.push_back(make_req(OP_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0002_0000,
                                32'd0));
    directed.push_back(make_req(OP_DIV, 32'h0001_0000, 32'd0, 32'h0003_0000, 32'h0004_0000));
    directed.push_back(make_req(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0));
    directed.push_back(make_req(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000));
    // quotient tie: 1/2 ulp
    directed.push_back(make_req(OP_DIV, 32'd1, 32'd0, 32'h0002_0000, 32'd0));
    directed.push_back(make_req(OP_DIV, 32'd1, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    directed.push_back(make_req(OP_CONJ, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF));
    directed.push_back(make_req(OP_CONJ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0));
    directed.push_back(make_req(OP_NEG, 32'h8000_0000, 32'h0001_0000, 32'd5, 32'd7));
    directed.push_back(make_req(OP_NEG, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0));
    directed.push_back(make_req(3'd6, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 32'd1));
    directed.push_back(make_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF));

    foreach (directed[i]) begin
      draw_gap(gap);
      send_request(directed[i], gap);
    end

    for (int n = 0; n < ITEMS; n++) begin
      if (n == PAUSE_AT) begin
        req_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        gap = 1;
      end else if (results_seen >= HOLD_AT - 40 && results_seen <= HOLD_AT + 5) begin
        gap = 0;
      end else begin
        draw_gap(gap);
      end
      send_request(random_request(), gap);
    end
    req_if.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < DRAIN_WAIT) begin
      @(posedge clk);
      drain++;
    end

    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
